// ----- src/rau_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the rational arithmetic unit
package rau_pkg;

    localparam int OP_W      = 3;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
    localparam int WIDE_W    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_CMP    = 3'd4,
        OP_REDUCE = 3'd5,
        OP_RECIP  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        MSEL_CROSS_A = 2'd0,
        MSEL_CROSS_B = 2'd1,
        MSEL_DENS    = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMBINE,
        ST_GCD,
        ST_DIVIDE,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     combine;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     reduce_fin;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            gcd_done;
        logic            div_done;
        logic            out_busy;
    } dp_status_t;

endpackage

// ----- src/rau_channels.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces
interface rau_req_if #(
    parameter int OPERAND_WIDTH = 16
) ();
    logic                            valid;
    logic                            ready;
    logic [rau_pkg::OP_W-1:0]        req_type;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if ();
    logic                                valid;
    logic                                ready;
    logic signed [rau_pkg::NUM_OUT_W-1:0] res_num;
    logic [rau_pkg::DEN_OUT_W-1:0]        res_den;
    logic                                is_equal;
    logic                                is_greater;
    logic                                is_less;
    logic                                div_by_zero;

    modport source (output valid, res_num, res_den, is_equal, is_greater, is_less,
                    div_by_zero, input ready);
    modport sink (input valid, res_num, res_den, is_equal, is_greater, is_less,
                  div_by_zero, output ready);
endinterface

// ----- src/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// rational arithmetic unit: fraction add, sub, mul, div, compare, reduce, reciprocal
//
// usage
//   req carries one word: opcode plus fractions A and B, OPERAND_WIDTH-bit signed
//   parts; a word is taken when req.valid and req.ready are both high
//   rsp carries one word per request: 33-bit signed numerator, 31-bit positive
//   denominator and the compare and divide-by-zero flags
//   operands are normalized on entry (zero denominator reads as one, a
//   negative denominator moves its sign to the numerator)
// sequence
//   add, sub, mul, div, compare, reciprocal: after accept the sequencer steps
//   through MUL0, MUL1, MUL2, COMBINE and FINISH; one shared multiplier forms
//   the three products in turn
//   reduce: after MUL0 the binary gcd takes one shift or subtract per cycle,
//   then both quotients come out of a bit-serial divider before REDUCE and FINISH
// throughput
//   one request in flight; req.ready is high only while the sequencer is idle,
//   so a new word can enter as soon as the previous result sits in rsp
// reset
//   rst_n clears the sequencer and rsp.valid; no state lives between requests
// stall
//   a finished result waits in the output register while rsp.ready is low; a
//   following result then holds in the datapath until that register frees
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input logic      clk,
    input logic      rst_n,
    rau_req_if.sink  req,
    rau_rsp_if.source rsp
);

    rau_pkg::ctrl_cmd_t  cmd;
    rau_pkg::dp_status_t status;

    // sequencer: drives req.ready and the datapath commands
    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: operands, multiplier, gcd, divider and the rsp register
    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req.req_type),
        .a_num       (req.a_num),
        .a_den       (req.a_den),
        .b_num       (req.b_num),
        .b_den       (req.b_den),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .res_num     (rsp.res_num),
        .res_den     (rsp.res_den),
        .is_equal    (rsp.is_equal),
        .is_greater  (rsp.is_greater),
        .is_less     (rsp.is_less),
        .div_by_zero (rsp.div_by_zero)
    );

endmodule

// ----- src/rau_datapath.sv -----
`timescale 1ns / 1ps
// operand registers, shared multiplier, gcd and divider lanes, result register
module rau_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rau_pkg::ctrl_cmd_t                  cmd,
    output rau_pkg::dp_status_t                 status,
    input  logic [rau_pkg::OP_W-1:0]            req_type,
    input  logic signed [OPERAND_WIDTH-1:0]     a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     b_den,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rau_pkg::NUM_OUT_W-1:0] res_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]        res_den,
    output logic                                is_equal,
    output logic                                is_greater,
    output logic                                is_less,
    output logic                                div_by_zero
);

    localparam int NW     = OPERAND_WIDTH + 1;
    localparam int MAG_W  = OPERAND_WIDTH;
    localparam int PROD_W = 2 * OPERAND_WIDTH + 2;
    localparam int ACC_W  = (2 * OPERAND_WIDTH + 1 > rau_pkg::WIDE_W) ?
                            rau_pkg::WIDE_W : 2 * OPERAND_WIDTH + 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    logic [rau_pkg::OP_W-1:0] op_reg, op_next;
    logic signed [NW-1:0]     an_reg, an_next, ad_reg, ad_next;
    logic signed [NW-1:0]     bn_reg, bn_next, bd_reg, bd_next;
    logic signed [ACC_W-1:0]  t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic signed [ACC_W-1:0]  rn_reg, rn_next, rd_reg, rd_next;
    logic                     eq_reg, eq_next, gt_reg, gt_next;
    logic                     lt_reg, lt_next, dz_reg, dz_next;
    logic [MAG_W-1:0]         gx_reg, gx_next, gy_reg, gy_next;
    logic [MAG_W-1:0]         dm_reg, dm_next, dd_reg, dd_next;
    logic [MAG_W-1:0]         g_reg, g_next;
    logic [MAG_W-1:0]         q1_reg, q1_next, q2_reg, q2_next;
    logic [MAG_W-1:0]         r1_reg, r1_next, r2_reg, r2_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [rau_pkg::NUM_OUT_W-1:0] res_num_reg, res_num_next;
    logic [rau_pkg::DEN_OUT_W-1:0]        res_den_reg, res_den_next;
    logic                     res_eq_reg, res_eq_next, res_gt_reg, res_gt_next;
    logic                     res_lt_reg, res_lt_next, res_dz_reg, res_dz_next;

    // normalized incoming operands
    logic signed [NW-1:0] in_an, in_ad, in_bn, in_bd;
    logic [MAG_W-1:0]     in_mag_a;
    // working values
    logic signed [NW-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  sum, diff, an_ext, ad_ext;
    logic signed [NW-1:0]     an_abs;
    logic [MAG_W-1:0]         mag_a;
    logic [MAG_W:0]           trial1, trial2;
    logic signed [rau_pkg::WIDE_W-1:0] wide_num, wide_den;

    always_comb
    begin
        in_an = NW'(a_num);
        in_ad = NW'(a_den);
        if (a_den == '0)
        begin
            in_ad = NW'(1);
        end
        else if (a_den[OPERAND_WIDTH-1])
        begin
            in_an = -NW'(a_num);
            in_ad = -NW'(a_den);
        end
        in_bn = NW'(b_num);
        in_bd = NW'(b_den);
        if (b_den == '0)
        begin
            in_bd = NW'(1);
        end
        else if (b_den[OPERAND_WIDTH-1])
        begin
            in_bn = -NW'(b_num);
            in_bd = -NW'(b_den);
        end
        in_mag_a = in_an[NW-1] ? MAG_W'(-in_an) : MAG_W'(in_an);
    end

    always_comb
    begin
        case (cmd.mul_sel)
            rau_pkg::MSEL_CROSS_A:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::MSEL_CROSS_B:
            begin
                mul_a = ad_reg;
                mul_b = bn_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
        prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
        sum    = t1_reg + t2_reg;
        diff   = t1_reg - t2_reg;
        an_ext = ACC_W'(an_reg);
        ad_ext = ACC_W'(ad_reg);
        an_abs = an_reg[NW-1] ? -an_reg : an_reg;
        mag_a  = an_abs[MAG_W-1:0];
        trial1 = {r1_reg, q1_reg[MAG_W-1]};
        trial2 = {r2_reg, q2_reg[MAG_W-1]};
    end

    always_comb
    begin
        op_next = op_reg;
        an_next = an_reg;
        ad_next = ad_reg;
        bn_next = bn_reg;
        bd_next = bd_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        rn_next = rn_reg;
        rd_next = rd_reg;
        eq_next = eq_reg;
        gt_next = gt_reg;
        lt_next = lt_reg;
        dz_next = dz_reg;
        gx_next = gx_reg;
        gy_next = gy_reg;
        dm_next = dm_reg;
        dd_next = dd_reg;
        g_next  = g_reg;
        q1_next = q1_reg;
        q2_next = q2_reg;
        r1_next = r1_reg;
        r2_next = r2_reg;
        cnt_next = cnt_reg;

        if (cmd.load)
        begin
            op_next = req_type;
            an_next = in_an;
            ad_next = in_ad;
            bn_next = in_bn;
            bd_next = in_bd;
            eq_next = 1'b0;
            gt_next = 1'b0;
            lt_next = 1'b0;
            dz_next = 1'b0;
            gx_next = in_mag_a;
            gy_next = in_ad[MAG_W-1:0];
            dm_next = in_mag_a;
            dd_next = in_ad[MAG_W-1:0];
        end

        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                rau_pkg::MSEL_CROSS_A: t1_next = ACC_W'(prod);
                rau_pkg::MSEL_CROSS_B: t2_next = ACC_W'(prod);
                default:               t3_next = ACC_W'(prod);
            endcase
        end

        if (cmd.combine)
        begin
            rn_next = an_ext;
            rd_next = ad_ext;
            case (op_reg)
                rau_pkg::OP_ADD:
                begin
                    rn_next = sum;
                    rd_next = t3_reg;
                end
                rau_pkg::OP_SUB:
                begin
                    rn_next = diff;
                    rd_next = t3_reg;
                end
                rau_pkg::OP_CMP:
                begin
                    rn_next = diff;
                    rd_next = t3_reg;
                    eq_next = (diff == '0);
                    lt_next = diff[ACC_W-1];
                    gt_next = (diff != '0) && !diff[ACC_W-1];
                end
                rau_pkg::OP_MUL:
                begin
                    rn_next = t1_reg;
                    rd_next = t3_reg;
                end
                rau_pkg::OP_DIV:
                begin
                    if (bn_reg == '0)
                    begin
                        dz_next = 1'b1;
                    end
                    else if (t2_reg[ACC_W-1])
                    begin
                        rn_next = -t1_reg;
                        rd_next = -t2_reg;
                    end
                    else
                    begin
                        rn_next = t1_reg;
                        rd_next = t2_reg;
                    end
                end
                rau_pkg::OP_RECIP:
                begin
                    // zero has no reciprocal and passes through
                    if (an_reg != '0)
                    begin
                        rn_next = an_reg[NW-1] ? -ad_ext : ad_ext;
                        rd_next = ACC_W'(mag_a);
                    end
                end
                default:
                begin
                    rn_next = an_ext;
                    rd_next = ad_ext;
                end
            endcase
        end

        // binary gcd: common twos come off the dividends as well
        if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_next = gx_reg >> 1;
                gy_next = gy_reg >> 1;
                dm_next = dm_reg >> 1;
                dd_next = dd_reg >> 1;
            end
            else if (!gx_reg[0])
            begin
                gx_next = gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_next = gy_reg >> 1;
            end
            else if (gx_reg >= gy_reg)
            begin
                gx_next = gx_reg - gy_reg;
            end
            else
            begin
                gy_next = gy_reg - gx_reg;
            end
        end

        if (cmd.div_init)
        begin
            g_next   = gx_reg | gy_reg;
            q1_next  = dm_reg;
            q2_next  = dd_reg;
            r1_next  = '0;
            r2_next  = '0;
            cnt_next = '0;
        end

        // restoring division, one quotient bit per lane per cycle
        if (cmd.div_step)
        begin
            if (trial1 >= {1'b0, g_reg})
            begin
                r1_next = MAG_W'(trial1 - {1'b0, g_reg});
                q1_next = {q1_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                r1_next = trial1[MAG_W-1:0];
                q1_next = {q1_reg[MAG_W-2:0], 1'b0};
            end
            if (trial2 >= {1'b0, g_reg})
            begin
                r2_next = MAG_W'(trial2 - {1'b0, g_reg});
                q2_next = {q2_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                r2_next = trial2[MAG_W-1:0];
                q2_next = {q2_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.reduce_fin)
        begin
            rn_next = an_reg[NW-1] ? -ACC_W'(q1_reg) : ACC_W'(q1_reg);
            rd_next = ACC_W'(q2_reg);
        end
    end

    // result register
    always_comb
    begin
        wide_num       = rau_pkg::WIDE_W'(rn_reg);
        wide_den       = rau_pkg::WIDE_W'(rd_reg);
        out_valid_next = out_valid_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_eq_next    = res_eq_reg;
        res_gt_next    = res_gt_reg;
        res_lt_next    = res_lt_reg;
        res_dz_next    = res_dz_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            res_num_next   = wide_num[rau_pkg::NUM_OUT_W-1:0];
            res_den_next   = wide_den[rau_pkg::DEN_OUT_W-1:0];
            res_eq_next    = eq_reg;
            res_gt_next    = gt_reg;
            res_lt_next    = lt_reg;
            res_dz_next    = dz_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        eq_reg      <= eq_next;
        gt_reg      <= gt_next;
        lt_reg      <= lt_next;
        dz_reg      <= dz_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        dm_reg      <= dm_next;
        dd_reg      <= dd_next;
        g_reg       <= g_next;
        q1_reg      <= q1_next;
        q2_reg      <= q2_next;
        r1_reg      <= r1_next;
        r2_reg      <= r2_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_eq_reg  <= res_eq_next;
        res_gt_reg  <= res_gt_next;
        res_lt_reg  <= res_lt_next;
        res_dz_reg  <= res_dz_next;
    end

    assign status.op       = op_reg;
    assign status.gcd_done = (gx_reg == '0) || (gy_reg == '0);
    assign status.div_done = (cnt_reg == CNT_W'(MAG_W));
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign res_num     = res_num_reg;
    assign res_den     = res_den_reg;
    assign is_equal    = res_eq_reg;
    assign is_greater  = res_gt_reg;
    assign is_less     = res_lt_reg;
    assign div_by_zero = res_dz_reg;

endmodule

// ----- src/rau_ctrl.sv -----
`timescale 1ns / 1ps
// sequencing state machine of the rational arithmetic unit
module rau_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rau_pkg::dp_status_t status,
    output rau_pkg::ctrl_cmd_t  cmd
);

    rau_pkg::state_t state_reg, state_next;
    logic            is_reduce;

    assign is_reduce = (status.op == rau_pkg::OP_REDUCE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rau_pkg::ST_MUL0;
                end
            end
            rau_pkg::ST_MUL0:
            begin
                state_next = is_reduce ? rau_pkg::ST_GCD : rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1:    state_next = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:    state_next = rau_pkg::ST_COMBINE;
            rau_pkg::ST_COMBINE: state_next = rau_pkg::ST_FINISH;
            rau_pkg::ST_GCD:
            begin
                if (status.gcd_done)
                begin
                    state_next = rau_pkg::ST_DIVIDE;
                end
            end
            rau_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = rau_pkg::ST_REDUCE;
                end
            end
            rau_pkg::ST_REDUCE:  state_next = rau_pkg::ST_FINISH;
            rau_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default:             state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.mul_sel = rau_pkg::MSEL_CROSS_A;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rau_pkg::ST_MUL0:
            begin
                cmd.mul_en  = !is_reduce;
                cmd.mul_sel = rau_pkg::MSEL_CROSS_A;
            end
            rau_pkg::ST_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MSEL_CROSS_B;
            end
            rau_pkg::ST_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MSEL_DENS;
            end
            rau_pkg::ST_COMBINE: cmd.combine = 1'b1;
            rau_pkg::ST_GCD:
            begin
                cmd.gcd_step = !status.gcd_done;
                cmd.div_init = status.gcd_done;
            end
            rau_pkg::ST_DIVIDE:  cmd.div_step = !status.div_done;
            rau_pkg::ST_REDUCE:  cmd.reduce_fin = 1'b1;
            rau_pkg::ST_FINISH:  cmd.out_load = !status.out_busy;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
